/* hdl/kpwdt_pkg.sv */
// kpwdt_pkg: types, codes and constants for the key-protected watchdog timer.
// No dependencies; imported by kpwdt_engine and key_protected_watchdog_timer_core.
`timescale 1ns / 1ps

package kpwdt_pkg;

	localparam int COUNT_BITS    = 24;
	localparam int LOW_FILL_BITS = 12;
	localparam int RESTART_BITS  = 12;
	localparam int PRESCALE_BITS = 12;

	localparam logic [11:0] MODE_KEY    = 12'hABC;
	localparam logic [11:0] CTRL_KEY    = 12'h248;
	localparam logic [15:0] RESTART_KEY = 16'h1999;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_CONTROL = 2'd1;
	localparam logic [1:0] REG_RESTART = 2'd2;
	localparam logic [1:0] REG_STATUS  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  reg_select;
		logic [31:0] write_data;
	} req_item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        write_accepted;
		logic        key_error;
		logic        counter_zero;
		logic        reset_request;
	} rsp_item_t;

	// Prescaler terminal count: 8, 64, 512 or 4096. One bit wider than the count.
	function automatic logic [PRESCALE_BITS:0] prescale_limit(input logic [1:0] sel);
		logic [PRESCALE_BITS:0] lim;
		lim = '0;
		case (sel)
			2'd0:    lim[3]  = 1'b1;
			2'd1:    lim[6]  = 1'b1;
			2'd2:    lim[9]  = 1'b1;
			default: lim[12] = 1'b1;
		endcase
		return lim;
	endfunction

endpackage

/* hdl/kpwdt_engine.sv */
// kpwdt_engine: watchdog register file, prescaler and down counter.
// Depends on kpwdt_pkg. Computes one item's result and next state per fire cycle.
`timescale 1ns / 1ps

module kpwdt_engine
	import kpwdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  req_item_t item,
	output rsp_item_t result
);

	localparam int RELOAD_W = RESTART_BITS + LOW_FILL_BITS;

	logic                     en_q, rst_en_q, irq_en_q;
	logic [1:0]               irq_len_q, psel_q;
	logic [RESTART_BITS-1:0]  restart_q;
	logic [PRESCALE_BITS-1:0] pcount_q;
	logic [COUNT_BITS-1:0]    dcount_q;
	logic                     zero_q;

	logic                     en_n, rst_en_n, irq_en_n;
	logic [1:0]               irq_len_n, psel_n;
	logic [RESTART_BITS-1:0]  restart_n;
	logic [PRESCALE_BITS-1:0] pcount_n, pcount_inc;
	logic [COUNT_BITS-1:0]    dcount_n;
	logic                     zero_n;

	logic [RELOAD_W+COUNT_BITS-1:0] reload_wide;
	logic [COUNT_BITS-1:0]          reload_val;

	// {restart, ones}, zero-padded then cut to the counter width
	assign reload_wide = {{COUNT_BITS{1'b0}}, restart_q, {LOW_FILL_BITS{1'b1}}};
	assign reload_val  = reload_wide[COUNT_BITS-1:0];
	assign pcount_inc  = pcount_q + 1'b1;

	always_comb begin
		en_n      = en_q;
		rst_en_n  = rst_en_q;
		irq_en_n  = irq_en_q;
		irq_len_n = irq_len_q;
		psel_n    = psel_q;
		restart_n = restart_q;
		pcount_n  = pcount_q;
		dcount_n  = dcount_q;
		zero_n    = zero_q;
		result    = '0;

		unique case (item.kind)
			KIND_WRITE: begin
				unique case (item.reg_select)
					REG_MODE: begin
						if (item.write_data[23:12] == MODE_KEY) begin
							en_n      = item.write_data[0];
							rst_en_n  = item.write_data[1];
							irq_en_n  = item.write_data[2];
							irq_len_n = item.write_data[8:7];
							result.write_accepted = 1'b1;
						end else begin
							result.key_error = 1'b1;
						end
					end
					REG_CONTROL: begin
						if (item.write_data[25:14] == CTRL_KEY) begin
							psel_n    = item.write_data[1:0];
							restart_n = item.write_data[13:2];
							result.write_accepted = 1'b1;
						end else begin
							result.key_error = 1'b1;
						end
					end
					REG_RESTART: begin
						if (item.write_data[15:0] == RESTART_KEY) begin
							dcount_n = reload_val;
							pcount_n = '0;
							zero_n   = 1'b0;
							result.write_accepted = 1'b1;
						end else begin
							result.key_error = 1'b1;
						end
					end
					default: ; // status is read-only
				endcase
			end
			KIND_READ: begin
				unique case (item.reg_select)
					REG_MODE:    result.read_data = {23'd0, irq_len_q, 4'd0,
						irq_en_q, rst_en_q, en_q};
					REG_CONTROL: result.read_data = {18'd0, restart_q, psel_q};
					REG_STATUS:  result.read_data = {31'd0, zero_q};
					default:     result.read_data = '0;
				endcase
			end
			KIND_TICK: begin
				if (en_q) begin
					if (pcount_inc == '0 ||
						{1'b0, pcount_inc} >= prescale_limit(psel_q)) begin
						pcount_n = '0;
						if (dcount_q != '0)
							dcount_n = dcount_q - 1'b1;
					end else begin
						pcount_n = pcount_inc;
					end
					if (dcount_n == '0)
						zero_n = 1'b1;
				end
			end
			default: ;
		endcase

		result.counter_zero  = zero_n;
		result.reset_request = (dcount_n == '0) && rst_en_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			rst_en_q  <= 1'b0;
			irq_en_q  <= 1'b0;
			irq_len_q <= '0;
			psel_q    <= '0;
			restart_q <= '1;
			pcount_q  <= '0;
			dcount_q  <= '1;
			zero_q    <= 1'b0;
		end else if (fire) begin
			en_q      <= en_n;
			rst_en_q  <= rst_en_n;
			irq_en_q  <= irq_en_n;
			irq_len_q <= irq_len_n;
			psel_q    <= psel_n;
			restart_q <= restart_n;
			pcount_q  <= pcount_n;
			dcount_q  <= dcount_n;
			zero_q    <= zero_n;
		end
	end

endmodule

/* hdl/key_protected_watchdog_timer_core.sv */
// key_protected_watchdog_timer_core: top level, input register and result register.
// Depends on kpwdt_pkg and kpwdt_engine.
`timescale 1ns / 1ps

// Key-protected watchdog timer. Each req transfer is a bus write, a bus read or one
// source clock tick; each produces exactly one rsp transfer, in order. Mode writes need
// key 0xABC in bits 23:12, control writes need 0x248 in bits 25:14, and a restart write
// needs 0x1999 in bits 15:0; a wrong key reports key_error and changes nothing. Enabled
// ticks run through a prescaler (divide by 8/64/512/4096) and count the 24-bit counter
// down; at zero it holds, counter_zero is set until the next restart, and reset_request
// follows if reset is enabled. Throughput is one transfer per cycle while rsp is not
// stalled: the item is registered, evaluated combinationally against the timer state,
// and its response is registered. A stalled rsp holds one item in the output register
// and one in the input register before req stalls.

module key_protected_watchdog_timer_core
	import kpwdt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	logic      req_valid_s1;
	req_item_t req_s1;
	logic      rsp_valid_q;
	rsp_item_t rsp_q;
	rsp_item_t result;
	logic      out_free;
	logic      advance;

	// output register can take a new result this cycle
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign advance   = req_valid_s1 && out_free;
	assign req_stall = req_valid_s1 && !out_free;

	kpwdt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (req_s1),
		.result (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= result;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
